@@ src/brb_pkg.sv @@
// Package for the byte ring buffer: opcodes, register indexes, defaults,
// field widths and the lane merge control word.
// No dependencies.
package brb_pkg;

  localparam int DEPTH_DEF = 1024;
  localparam int LANES_DEF = 8;

  localparam int OP_W   = 3;
  localparam int DATA_W = 64;
  localparam int CNT_W  = 4;
  localparam int AMT_W  = 10;
  localparam int IDX_W  = 2;

  localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
  localparam logic [OP_W-1:0] OP_READ  = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
  localparam logic [OP_W-1:0] OP_SKIP  = 3'd3;
  localparam logic [OP_W-1:0] OP_ADV   = 3'd4;
  localparam logic [OP_W-1:0] OP_RESET = 3'd5;
  localparam logic [OP_W-1:0] OP_FIND  = 3'd6;

  localparam logic [IDX_W-1:0] REG_SIZE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_NEEDLE = 2'd1;
  localparam logic [IDX_W-1:0] REG_NLEN   = 2'd2;

  localparam logic [CNT_W-1:0] NEEDLE_MAX = 4'd8;

  typedef struct packed {
    logic [CNT_W-1:0] take;   // lanes that carry read or peek bytes
    logic [CNT_W-1:0] chunk;  // needle byte offset of lane 0
    logic [CNT_W-1:0] nlen;   // needle bytes in use
  } brb_ctl_t;

endpackage

@@ src/brb_lane.sv @@
// One lane: a full replica of the ring storage with one write and one
// registered read port, plus a byte compare against the lane's needle byte.
// Depends on brb_pkg.
module brb_lane #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [$clog2(DEPTH)-1:0]   waddr,
  input  logic [7:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]   raddr,
  input  logic [7:0]                 needle,
  output logic [7:0]                 rdata,
  output logic                       eq
);
  import brb_pkg::*;

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign eq = (rdata == needle);

endmodule

@@ src/brb_merge.sv @@
// Merge stage: packs the lane bytes into a masked word for read and peek,
// and reduces the lane compares into one match flag for find.
// Depends on brb_pkg.
module brb_merge #(
  parameter int LANES = brb_pkg::LANES_DEF
) (
  input  brb_pkg::brb_ctl_t          ctl,
  input  logic [LANES-1:0][7:0]      rdata,
  input  logic [LANES-1:0]           eq,
  output logic [brb_pkg::DATA_W-1:0] dout,
  output logic                       all_eq
);
  import brb_pkg::*;

  logic [CNT_W:0] pos;

  always_comb begin
    dout   = '0;
    all_eq = 1'b1;
    pos    = '0;
    for (int k = 0; k < LANES; k++) begin
      if (CNT_W'(k) < ctl.take) begin
        dout[k*8 +: 8] = rdata[k];
      end
      pos = {1'b0, ctl.chunk} + (CNT_W+1)'(k);
      // Lanes past the end of the needle do not take part.
      if (pos < {1'b0, ctl.nlen} && !eq[k]) begin
        all_eq = 1'b0;
      end
    end
  end

endmodule

@@ src/byte_ring_buffer_with_peek_find.sv @@
// Byte ring buffer with peek and find. One operation is taken when start is
// high and busy is low; its result word appears for one cycle with done high
// and must be taken then. Reset, skip, advance and unknown opcodes pass
// through decode to finish, read and peek add a lane read and a merge step,
// write adds the write sequencer (it stores one byte per cycle into every lane
// replica), and find adds a lane memory read and a compare step for each
// needle chunk of each candidate offset tried.
// A configuration write is taken in any cycle; write it only while idle.
module byte_ring_buffer_with_peek_find #(
  parameter int DEPTH = brb_pkg::DEPTH_DEF,
  parameter int LANES = brb_pkg::LANES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [brb_pkg::OP_W-1:0]    opcode,
  input  logic [brb_pkg::DATA_W-1:0]  data_in,
  input  logic [brb_pkg::CNT_W-1:0]   byte_count,
  input  logic                        all_required,
  input  logic [brb_pkg::AMT_W-1:0]   amount,
  input  logic                        cfg_we,
  input  logic [brb_pkg::IDX_W-1:0]   cfg_index,
  input  logic [brb_pkg::DATA_W-1:0]  cfg_data,
  output logic                        done,
  output logic                        ok,
  output logic [brb_pkg::AMT_W-1:0]   moved,
  output logic [brb_pkg::DATA_W-1:0]  data_out,
  output logic [brb_pkg::AMT_W-1:0]   free_bytes,
  output logic [brb_pkg::AMT_W-1:0]   used_bytes,
  output logic [brb_pkg::AMT_W-1:0]   found_at,
  output logic [brb_pkg::AMT_W-1:0]   linear_read_len,
  output logic [brb_pkg::AMT_W-1:0]   linear_write_len
);
  import brb_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int SW = $clog2(DEPTH + 1);
  localparam int CW = (SW > AMT_W ? SW : AMT_W) + 4;
  localparam int SIZE_RST = (DEPTH < 1024) ? DEPTH : 1024;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_DEC  = 8'b00000010,
    S_WR   = 8'b00000100,
    S_RD   = 8'b00001000,
    S_RDW  = 8'b00010000,
    S_FRD  = 8'b00100000,
    S_FCMP = 8'b01000000,
    S_FIN  = 8'b10000000
  } state_t;

  state_t state;

  logic [AW-1:0]     wi, ri, wptr;
  logic [SW-1:0]     size;
  logic [DATA_W-1:0] needle_q;
  logic [CNT_W-1:0]  nlen_q;

  logic [OP_W-1:0]   op_q;
  logic [DATA_W-1:0] din_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              all_q;
  logic [AMT_W-1:0]  amt_q;

  logic [CNT_W-1:0]  wcnt, chunk;
  logic [AW-1:0]     base;
  logic [CW-1:0]     xpos, xlast;

  logic              ok_r;
  logic [CW-1:0]     moved_r, found_r;
  logic [DATA_W-1:0] dout_r;

  logic [CW-1:0] size_w, wi_w, ri_w, used_w, free_w, lin_rd, lin_wr;
  logic [CW-1:0] cnt_w, amt_w, nl_w, cfg_v;
  logic [CW-1:0] n_wr, n_rd, n_pk, n_sk, n_ad;
  logic [CNT_W-1:0] nl_sat, cnt_in;

  function automatic logic [CW-1:0] wrap1(input logic [CW-1:0] s,
                                          input logic [CW-1:0] m);
    return (s >= m) ? s - m : s;
  endfunction

  assign size_w = CW'(size);
  assign wi_w   = CW'(wi);
  assign ri_w   = CW'(ri);
  assign used_w = (wi >= ri) ? wi_w - ri_w : size_w - (ri_w - wi_w);
  assign free_w = size_w - CW'(1) - used_w;
  assign lin_rd = (wi > ri) ? wi_w - ri_w : ((ri > wi) ? size_w - ri_w : '0);
  assign lin_wr = (wi >= ri) ? size_w - wi_w - ((ri == '0) ? CW'(1) : CW'(0))
                             : ri_w - wi_w - CW'(1);

  assign cnt_w  = CW'(cnt_q);
  assign amt_w  = CW'(amt_q);
  assign nl_sat = (nlen_q > NEEDLE_MAX) ? NEEDLE_MAX : nlen_q;
  assign nl_w   = CW'(nl_sat);
  assign cnt_in = (byte_count > CNT_W'(LANES)) ? CNT_W'(LANES) : byte_count;

  assign n_wr = (cnt_w < free_w) ? cnt_w : free_w;
  assign n_rd = (cnt_w < used_w) ? cnt_w : used_w;
  assign n_pk = (cnt_w < used_w - amt_w) ? cnt_w : used_w - amt_w;
  assign n_sk = (amt_w < used_w) ? amt_w : used_w;
  assign n_ad = (amt_w < free_w) ? amt_w : free_w;

  assign cfg_v = CW'(cfg_data[10:0]);

  // Lane array and merge stage.
  logic [LANES-1:0][7:0]  lane_rdata, lane_needle;
  logic [LANES-1:0][AW-1:0] lane_addr;
  logic [LANES-1:0]       lane_eq;
  logic                   lane_we;
  logic [7:0]             lane_wdata;
  brb_ctl_t               mctl;
  logic [DATA_W-1:0]      m_dout;
  logic                   m_all_eq;

  assign lane_we    = (state == S_WR);
  assign lane_wdata = din_q[wcnt[2:0]*8 +: 8];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [CNT_W:0] nidx;
    logic [CW-1:0]  asum;

    assign nidx = {1'b0, chunk} + (CNT_W+1)'(k);
    assign lane_needle[k] = (nidx < (CNT_W+1)'(8)) ? needle_q[nidx[2:0]*8 +: 8] : 8'h00;
    assign asum = wrap1(CW'(base) + CW'(chunk) + CW'(k), size_w);
    assign lane_addr[k] = asum[AW-1:0];

    brb_lane #(.DEPTH(DEPTH)) u_lane (
      .clk    (clk),
      .we     (lane_we),
      .waddr  (wptr),
      .wdata  (lane_wdata),
      .raddr  (lane_addr[k]),
      .needle (lane_needle[k]),
      .rdata  (lane_rdata[k]),
      .eq     (lane_eq[k])
    );
  end

  assign mctl.take  = moved_r[CNT_W-1:0];
  assign mctl.chunk = chunk;
  assign mctl.nlen  = nl_sat;

  brb_merge #(.LANES(LANES)) u_merge (
    .ctl    (mctl),
    .rdata  (lane_rdata),
    .eq     (lane_eq),
    .dout   (m_dout),
    .all_eq (m_all_eq)
  );

  assign busy = (state != S_IDLE);

  logic [CW-1:0] wptr_inc, base_inc;
  assign wptr_inc = wrap1(CW'(wptr) + CW'(1), size_w);
  assign base_inc = wrap1(CW'(base) + CW'(1), size_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      wi       <= '0;
      ri       <= '0;
      size     <= SW'(SIZE_RST);
      needle_q <= '0;
      nlen_q   <= CNT_W'(1);
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SIZE: begin
            if (cfg_v < CW'(2)) begin
              size <= SW'(2);
            end else if (cfg_v > CW'(DEPTH)) begin
              size <= SW'(DEPTH);
            end else begin
              size <= cfg_v[SW-1:0];
            end
            wi <= '0;
            ri <= '0;
          end
          REG_NEEDLE: needle_q <= cfg_data;
          REG_NLEN:   nlen_q   <= cfg_data[CNT_W-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op_q  <= opcode;
            din_q <= data_in;
            cnt_q <= cnt_in;
            all_q <= all_required;
            amt_q <= amount;
            state <= S_DEC;
          end
        end
        S_DEC: begin
          ok_r    <= 1'b0;
          moved_r <= '0;
          found_r <= '0;
          dout_r  <= '0;
          chunk   <= '0;
          wcnt    <= '0;
          state   <= S_FIN;
          case (op_q)
            OP_WRITE: begin
              if (!(cnt_w == '0 || free_w == '0 || (all_q && free_w < cnt_w))) begin
                ok_r    <= 1'b1;
                moved_r <= n_wr;
                wptr    <= wi;
                state   <= S_WR;
              end
            end
            OP_READ: begin
              if (!(cnt_w == '0 || used_w == '0 || (all_q && used_w < cnt_w))) begin
                ok_r    <= 1'b1;
                moved_r <= n_rd;
                base    <= ri;
                state   <= S_RD;
              end
            end
            OP_PEEK: begin
              if (!(cnt_w == '0 || amt_w >= used_w)) begin
                ok_r    <= 1'b1;
                moved_r <= n_pk;
                base    <= AW'(wrap1(ri_w + amt_w, size_w));
                state   <= S_RD;
              end
            end
            OP_SKIP: begin
              moved_r <= n_sk;
              ok_r    <= (n_sk != '0);
              ri      <= AW'(wrap1(ri_w + n_sk, size_w));
            end
            OP_ADV: begin
              moved_r <= n_ad;
              ok_r    <= (n_ad != '0);
              wi      <= AW'(wrap1(wi_w + n_ad, size_w));
            end
            OP_RESET: begin
              ok_r <= 1'b1;
              wi   <= '0;
              ri   <= '0;
            end
            OP_FIND: begin
              if (!(nl_w == '0 || used_w < nl_w + amt_w)) begin
                xpos  <= amt_w;
                xlast <= used_w - nl_w;
                base  <= AW'(wrap1(ri_w + amt_w, size_w));
                state <= S_FRD;
              end
            end
            default: ;
          endcase
        end
        S_WR: begin
          wptr <= wptr_inc[AW-1:0];
          wcnt <= wcnt + CNT_W'(1);
          if (CW'(wcnt) == moved_r - CW'(1)) begin
            wi    <= wptr_inc[AW-1:0];
            state <= S_FIN;
          end
        end
        S_RD: state <= S_RDW;
        S_RDW: begin
          dout_r <= m_dout;
          if (op_q == OP_READ) begin
            ri <= AW'(wrap1(ri_w + moved_r, size_w));
          end
          state <= S_FIN;
        end
        S_FRD: state <= S_FCMP;
        S_FCMP: begin
          if (m_all_eq) begin
            if (CW'(chunk) + CW'(LANES) >= nl_w) begin
              ok_r    <= 1'b1;
              found_r <= xpos;
              state   <= S_FIN;
            end else begin
              chunk <= chunk + CNT_W'(LANES);
              state <= S_FRD;
            end
          end else if (xpos == xlast) begin
            state <= S_FIN;
          end else begin
            xpos  <= xpos + CW'(1);
            base  <= base_inc[AW-1:0];
            chunk <= '0;
            state <= S_FRD;
          end
        end
        S_FIN: begin
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result word, loaded as the operation finishes.
  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      ok               <= ok_r;
      moved            <= AMT_W'(moved_r);
      data_out         <= dout_r;
      found_at         <= AMT_W'(found_r);
      free_bytes       <= AMT_W'(free_w);
      used_bytes       <= AMT_W'(used_w);
      linear_read_len  <= AMT_W'(lin_rd);
      linear_write_len <= AMT_W'(lin_wr);
    end
  end

endmodule
